[hw/rtl/plr_pkg.sv]
// Shared types and constants of the profile linear resampler.
// Holds the transaction structs, the mode and status codes and the state encoding.
// Depends on nothing.
`timescale 1ns / 1ps

package plr_pkg;

	localparam int VALUE_W        = 32;
	localparam int MESH_W         = 16;
	localparam int LANES          = 5;
	localparam int MAX_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DEPTH_ONE      = 65536;
	localparam logic [MESH_W-1:0] MESH_RESET = 16'd100;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef value_t [LANES-1:0] lanes_t;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_EMIT   = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FEW      = 2'd1,
		STAT_FINISHED = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] mode;
		value_t     point_depth;
		value_t     speed_p_real;
		value_t     speed_p_imag;
		value_t     speed_s_real;
		value_t     speed_s_imag;
		value_t     density_in;
	} in_item_t;

	typedef struct packed {
		logic [MESH_W-1:0] mesh_index;
		value_t            mesh_depth;
		value_t            out_p_real;
		value_t            out_p_imag;
		value_t            out_s_real;
		value_t            out_s_imag;
		value_t            out_density;
		logic              final_point;
		logic [1:0]        status;
	} out_item_t;

	// One stored profile point
	typedef struct packed {
		value_t depth;
		lanes_t vals;
	} row_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TOP,
		S_BOT,
		S_BCAP,
		S_DIV,
		S_MULI,
		S_MUL,
		S_ZSAT,
		S_SEG,
		S_WALK_RD,
		S_WALK_CMP,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_FRAC,
		S_BLI,
		S_BLEND,
		S_DONE
	} state_t;

endpackage

[hw/rtl/profile_linear_resampler.sv]
// Profile linear resampler top level: profile memory, sequencer and bit-serial datapath.
// Depends on plr_pkg.
`timescale 1ns / 1ps

// Usage:
//   request/start/busy: a transaction is taken at a clock edge with start high and
//   busy low. Mode append stores a profile point, clear empties the profile, emit
//   asks for the next mesh point; the unused mode is ignored.
//   result/result_valid: each emit yields one result, shown for exactly one cycle
//   with result_valid high. The receiver cannot stall; results must be taken.
//   cfg_we/cfg_wdata: write mesh_segments, only while busy is low.
// Sequencing:
//   Append, clear and ignored transactions leave busy low. An emit that fails a
//   check (overflow, too few points, run finished) also leaves busy low and shows
//   its status result the cycle after. A normal emit keeps busy high through the
//   reads, the step division, the mesh depth multiply, the segment walk, the
//   fraction division and the blend; its result shows in the first cycle with busy low.
//   The last mesh point skips the multiply, a fraction that clamps to 0 or 1 skips
//   its division, and only mesh point 0 runs the serial step division. These
//   serial units and the one memory read port set how long busy stays high.
// Reset:
//   Clears the point count, run position, step, overflow flag and sets
//   mesh_segments to 100. The profile memory is not cleared.
module profile_linear_resampler #(
	parameter int MAX_POINTS = plr_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = plr_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  plr_pkg::in_item_t          request,
	output logic                       result_valid,
	output plr_pkg::out_item_t         result,
	input  logic                       cfg_we,
	input  logic [plr_pkg::MESH_W-1:0] cfg_wdata
);

	localparam int VW     = plr_pkg::VALUE_W;
	localparam int MW     = plr_pkg::MESH_W;
	localparam int NL     = plr_pkg::LANES;
	localparam int FB     = FRAC_BITS;
	localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PW     = $clog2(MAX_POINTS + 1);
	localparam int DW     = VW + 1;
	localparam int FW     = VW + 2;
	localparam int AW_MUL = VW + MW + 2;
	localparam int BW     = DW + FB + 1;
	localparam int STEP_W = $clog2(((DW > FB) ? DW : FB) + 1);

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};
	localparam logic [BW-1:0] HALF = BW'(1) << (FB - 1);

	// Control state
	plr_pkg::state_t state_q, state_d;
	logic [PW-1:0]   pts_q;
	logic [MW:0]     next_idx_q;
	logic [AW-1:0]   segment_index_q;
	plr_pkg::value_t step_q;
	logic            ovf_q;
	logic [MW-1:0]   mesh_segments_q;
	logic            result_valid_q;

	// Datapath registers
	plr_pkg::row_t    mem [MAX_POINTS];
	plr_pkg::row_t    rd_row_q, row_a_q, row_b_q;
	logic [AW-1:0]    rd_addr;
	plr_pkg::value_t  top_q, bot_q, z_q;
	logic [AW-1:0]    seg_q;
	logic [STEP_W-1:0] cnt_q;
	logic [MW-1:0]    drem_q;
	logic [DW-1:0]    dquo_q;
	logic             dneg_q;
	logic signed [AW_MUL-1:0] macc_q, mcand_q;
	logic [MW-1:0]    mplier_q;
	logic [FW-1:0]    frem_q, fden_q;
	logic [FB:0]      r_q;
	logic [FB-1:0]    rsh_q;
	logic [BW-1:0]    bm_q   [NL];
	logic [BW-1:0]    bacc_q [NL];
	logic             bneg_q [NL];
	plr_pkg::out_item_t result_q;

	// Decoded helpers
	logic [MW-1:0]    ms;
	logic             emit_req, emit_err;
	plr_pkg::status_t err_code;
	logic [AW-1:0]    seg_lim;
	logic [MW:0]      dtrial;
	logic             dge;
	plr_pkg::value_t  step_sat;
	plr_pkg::value_t  z_sat;
	logic signed [FW-1:0] fn0, fd0, fn, fd;
	logic             frac_zero, frac_one;
	logic [FW-1:0]    ftrial;
	logic signed [DW-1:0] dlt [NL];
	plr_pkg::value_t  blended [NL];
	logic [BW-1:0]    bsum [NL];
	logic [DW-1:0]    bq [NL];
	logic [DW-1:0]    dbot;

	assign ms       = (mesh_segments_q == '0) ? MW'(1) : mesh_segments_q;
	assign emit_req = start && (request.mode == plr_pkg::MODE_EMIT);
	assign seg_lim  = AW'(pts_q - PW'(2));

	// Check order: overflow, too few points, run finished
	always_comb begin
		emit_err = 1'b1;
		err_code = plr_pkg::STAT_OVERFLOW;
		if (ovf_q) begin
			err_code = plr_pkg::STAT_OVERFLOW;
		end else if (pts_q < PW'(2)) begin
			err_code = plr_pkg::STAT_FEW;
		end else if (next_idx_q > {1'b0, ms}) begin
			err_code = plr_pkg::STAT_FINISHED;
		end else begin
			emit_err = 1'b0;
			err_code = plr_pkg::STAT_OK;
		end
	end

	// Step division: one quotient bit per cycle
	assign dtrial = {drem_q, dquo_q[DW-1]};
	assign dge    = dtrial >= {1'b0, ms};
	assign dbot   = DW'(rd_row_q.depth) - DW'(top_q);

	always_comb begin
		logic [DW-1:0] qn;
		qn = {dquo_q[DW-2:0], dge};
		if (!dneg_q) begin
			step_sat = (qn > DW'(VMAX)) ? VMAX : VW'(qn);
		end else if (qn > {1'b0, VMIN}) begin
			step_sat = VMIN;
		end else begin
			step_sat = VW'(-qn);
		end
	end

	// Saturate the mesh depth
	always_comb begin
		if (macc_q > AW_MUL'(VMAX)) begin
			z_sat = VMAX;
		end else if (macc_q < AW_MUL'(VMIN)) begin
			z_sat = VMIN;
		end else begin
			z_sat = VW'(macc_q);
		end
	end

	// Fraction setup from the bracketing pair
	always_comb begin
		fn0 = FW'(z_q) - FW'(row_a_q.depth);
		fd0 = FW'(rd_row_q.depth) - FW'(row_a_q.depth);
		if (fd0 == '0) begin
			fd0 = FW'(plr_pkg::DEPTH_ONE);
		end
		if (fd0 < 0) begin
			fn = -fn0;
			fd = -fd0;
		end else begin
			fn = fn0;
			fd = fd0;
		end
		frac_zero = fn <= 0;
		frac_one  = fn >= fd;
	end

	assign ftrial = {frem_q[FW-2:0], 1'b0};

	// Lane differences and final blend
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			dlt[l]  = DW'(row_b_q.vals[l]) - DW'(row_a_q.vals[l]);
			bsum[l] = bacc_q[l] + HALF;
			bq[l]   = bsum[l][FB +: DW];
			if (r_q[FB]) begin
				blended[l] = row_b_q.vals[l];
			end else if (bneg_q[l]) begin
				blended[l] = VW'(DW'(row_a_q.vals[l]) - bq[l]);
			end else begin
				blended[l] = VW'(DW'(row_a_q.vals[l]) + bq[l]);
			end
		end
	end

	// Next state and read address
	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		case (state_q)
			plr_pkg::S_IDLE: begin
				if (emit_req && !emit_err) begin
					state_d = plr_pkg::S_TOP;
				end
			end
			plr_pkg::S_TOP: state_d = plr_pkg::S_BOT;
			plr_pkg::S_BOT: begin
				rd_addr = AW'(pts_q - PW'(1));
				state_d = plr_pkg::S_BCAP;
			end
			plr_pkg::S_BCAP: begin
				if (next_idx_q == '0) begin
					state_d = plr_pkg::S_DIV;
				end else if (next_idx_q == {1'b0, ms}) begin
					state_d = plr_pkg::S_SEG;
				end else begin
					state_d = plr_pkg::S_MULI;
				end
			end
			plr_pkg::S_DIV: begin
				if (cnt_q == STEP_W'(DW - 1)) begin
					state_d = plr_pkg::S_MULI;
				end
			end
			plr_pkg::S_MULI: state_d = plr_pkg::S_MUL;
			plr_pkg::S_MUL: begin
				if (cnt_q == STEP_W'(MW - 1)) begin
					state_d = plr_pkg::S_ZSAT;
				end
			end
			plr_pkg::S_ZSAT: state_d = plr_pkg::S_SEG;
			plr_pkg::S_SEG:  state_d = plr_pkg::S_WALK_RD;
			plr_pkg::S_WALK_RD: begin
				rd_addr = seg_q + AW'(1);
				state_d = (seg_q < seg_lim) ? plr_pkg::S_WALK_CMP : plr_pkg::S_RD_A;
			end
			plr_pkg::S_WALK_CMP: begin
				state_d = (z_q > rd_row_q.depth) ? plr_pkg::S_WALK_RD : plr_pkg::S_RD_A;
			end
			plr_pkg::S_RD_A: begin
				rd_addr = seg_q;
				state_d = plr_pkg::S_RD_B;
			end
			plr_pkg::S_RD_B: begin
				rd_addr = seg_q + AW'(1);
				state_d = plr_pkg::S_RD_C;
			end
			plr_pkg::S_RD_C: begin
				state_d = (frac_zero || frac_one) ? plr_pkg::S_BLI : plr_pkg::S_FRAC;
			end
			plr_pkg::S_FRAC: begin
				if (cnt_q == STEP_W'(FB - 1)) begin
					state_d = plr_pkg::S_BLI;
				end
			end
			plr_pkg::S_BLI: state_d = plr_pkg::S_BLEND;
			plr_pkg::S_BLEND: begin
				if (cnt_q == STEP_W'(FB - 1)) begin
					state_d = plr_pkg::S_DONE;
				end
			end
			plr_pkg::S_DONE: state_d = plr_pkg::S_IDLE;
			default: state_d = plr_pkg::S_IDLE;
		endcase
	end

	// Profile memory: append writes, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == plr_pkg::S_IDLE && start && request.mode == plr_pkg::MODE_APPEND
				&& pts_q < PW'(MAX_POINTS)) begin
			mem[AW'(pts_q)] <= '{depth: request.point_depth,
				vals: {request.speed_p_real, request.speed_p_imag, request.speed_s_real,
					request.speed_s_imag, request.density_in}};
		end
		rd_row_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= plr_pkg::S_IDLE;
			pts_q           <= '0;
			next_idx_q      <= '0;
			segment_index_q <= '0;
			step_q          <= '0;
			ovf_q           <= 1'b0;
			mesh_segments_q <= plr_pkg::MESH_RESET;
			result_valid_q  <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				mesh_segments_q <= cfg_wdata;
			end
			case (state_q)
				plr_pkg::S_IDLE: begin
					if (start) begin
						case (request.mode)
							plr_pkg::MODE_APPEND: begin
								if (pts_q < PW'(MAX_POINTS)) begin
									pts_q <= pts_q + PW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
								next_idx_q      <= '0;
								segment_index_q <= '0;
							end
							plr_pkg::MODE_CLEAR: begin
								pts_q           <= '0;
								ovf_q           <= 1'b0;
								next_idx_q      <= '0;
								segment_index_q <= '0;
								step_q          <= '0;
							end
							plr_pkg::MODE_EMIT: begin
								result_valid_q <= emit_err;
							end
							default: ;
						endcase
					end
				end
				plr_pkg::S_DIV: begin
					if (cnt_q == STEP_W'(DW - 1)) begin
						step_q <= step_sat;
					end
				end
				plr_pkg::S_DONE: begin
					result_valid_q  <= 1'b1;
					segment_index_q <= seg_q;
					next_idx_q      <= next_idx_q + (MW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			plr_pkg::S_IDLE: begin
				if (emit_req && emit_err) begin
					result_q <= '{status: err_code, default: '0};
				end
			end
			plr_pkg::S_BOT: top_q <= rd_row_q.depth;
			plr_pkg::S_BCAP: begin
				bot_q  <= rd_row_q.depth;
				z_q    <= rd_row_q.depth;
				cnt_q  <= '0;
				drem_q <= '0;
				dneg_q <= dbot[DW-1];
				dquo_q <= dbot[DW-1] ? -dbot : dbot;
			end
			plr_pkg::S_DIV: begin
				cnt_q  <= cnt_q + STEP_W'(1);
				drem_q <= dge ? MW'(dtrial - {1'b0, ms}) : MW'(dtrial);
				dquo_q <= {dquo_q[DW-2:0], dge};
			end
			plr_pkg::S_MULI: begin
				cnt_q    <= '0;
				macc_q   <= AW_MUL'(top_q);
				mcand_q  <= (next_idx_q == '0) ? '0 : AW_MUL'(step_q);
				mplier_q <= next_idx_q[MW-1:0];
			end
			plr_pkg::S_MUL: begin
				cnt_q    <= cnt_q + STEP_W'(1);
				if (mplier_q[0]) begin
					macc_q <= macc_q + mcand_q;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
			end
			plr_pkg::S_ZSAT: z_q <= z_sat;
			plr_pkg::S_SEG: begin
				seg_q <= (segment_index_q > seg_lim) ? seg_lim : segment_index_q;
			end
			plr_pkg::S_WALK_CMP: begin
				if (z_q > rd_row_q.depth) begin
					seg_q <= seg_q + AW'(1);
				end
			end
			plr_pkg::S_RD_B: row_a_q <= rd_row_q;
			plr_pkg::S_RD_C: begin
				row_b_q <= rd_row_q;
				cnt_q   <= '0;
				frem_q  <= FW'(fn);
				fden_q  <= FW'(fd);
				if (frac_zero) begin
					r_q <= '0;
				end else if (frac_one) begin
					r_q <= FRAC_ONE;
				end else begin
					r_q <= '0;
				end
			end
			plr_pkg::S_FRAC: begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (ftrial >= fden_q) begin
					frem_q <= ftrial - fden_q;
					r_q    <= {r_q[FB-1:0], 1'b1};
				end else begin
					frem_q <= ftrial;
					r_q    <= {r_q[FB-1:0], 1'b0};
				end
			end
			plr_pkg::S_BLI: begin
				cnt_q <= '0;
				rsh_q <= r_q[FB-1:0];
				for (int l = 0; l < NL; l++) begin
					bneg_q[l] <= dlt[l] < 0;
					bm_q[l]   <= BW'(dlt[l] < 0 ? -dlt[l] : dlt[l]);
					bacc_q[l] <= '0;
				end
			end
			plr_pkg::S_BLEND: begin
				cnt_q <= cnt_q + STEP_W'(1);
				rsh_q <= rsh_q >> 1;
				for (int l = 0; l < NL; l++) begin
					if (rsh_q[0]) begin
						bacc_q[l] <= bacc_q[l] + bm_q[l];
					end
					bm_q[l] <= bm_q[l] << 1;
				end
			end
			plr_pkg::S_DONE: begin
				result_q.mesh_index  <= next_idx_q[MW-1:0];
				result_q.mesh_depth  <= (next_idx_q == {1'b0, ms}) ? bot_q : z_q;
				result_q.out_p_real  <= blended[4];
				result_q.out_p_imag  <= blended[3];
				result_q.out_s_real  <= blended[2];
				result_q.out_s_imag  <= blended[1];
				result_q.out_density <= blended[0];
				result_q.final_point <= next_idx_q == {1'b0, ms};
				result_q.status      <= plr_pkg::STAT_OK;
			end
			default: ;
		endcase
	end

	assign busy         = state_q != plr_pkg::S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench of profile_linear_resampler: directed table, then random runs.
// Predicts every mesh point in its own model of the resampler; depends on plr_pkg.
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	plr_pkg::in_item_t request;
	logic result_valid;
	plr_pkg::out_item_t result;
	logic cfg_we;
	logic [plr_pkg::MESH_W-1:0] cfg_wdata;

	profile_linear_resampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result_valid(result_valid), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Predicted resampler state
	longint depth_mem[plr_pkg::MAX_POINTS_DEF];
	longint lane_mem[plr_pkg::MAX_POINTS_DEF][plr_pkg::LANES];
	int points_held;
	int next_point;
	int walk_seg;
	longint mesh_step;
	bit profile_overflow;
	int mesh_count;

	plr_pkg::out_item_t expected_points[$];
	int mismatches;
	int items_sent;
	int points_seen;
	int idle_cycles;
	int gap_pct;

	typedef struct {
		plr_pkg::in_item_t it;
		bit                fixed;
		plr_pkg::status_t  st;
	} stim_row_t;
	stim_row_t stim_rows[$];

	function automatic longint sat_value(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint depth_fraction(longint num, longint den);
		if (den == 0) den = plr_pkg::DEPTH_ONE;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0) return 0;
		if (num >= den) return 64'd1 << plr_pkg::FRAC_BITS_DEF;
		return (num << plr_pkg::FRAC_BITS_DEF) / den;
	endfunction

	function automatic longint blend_lane(longint a, longint b, longint r);
		longint d;
		longint m;
		longint q;
		if (r >= (64'd1 << plr_pkg::FRAC_BITS_DEF)) return b;
		d = b - a;
		m = (d < 0) ? -d : d;
		q = (m * r + (64'd1 << (plr_pkg::FRAC_BITS_DEF - 1))) >>> plr_pkg::FRAC_BITS_DEF;
		return (d < 0) ? a - q : a + q;
	endfunction

	function automatic plr_pkg::out_item_t status_only(plr_pkg::status_t st);
		plr_pkg::out_item_t o;
		o = '0;
		o.status = st;
		return o;
	endfunction

	// Advance the predicted state by one transaction; report whether it yields a result
	function automatic bit predict_mesh_point(plr_pkg::in_item_t it,
		output plr_pkg::out_item_t o);
		int ms;
		int seg;
		longint top;
		longint bot;
		longint z;
		longint r;
		longint v[plr_pkg::LANES];
		o = '0;
		case (plr_pkg::mode_t'(it.mode))
			plr_pkg::MODE_APPEND: begin
				if (points_held >= plr_pkg::MAX_POINTS_DEF) begin
					profile_overflow = 1'b1;
				end else begin
					depth_mem[points_held] = it.point_depth;
					lane_mem[points_held][0] = it.speed_p_real;
					lane_mem[points_held][1] = it.speed_p_imag;
					lane_mem[points_held][2] = it.speed_s_real;
					lane_mem[points_held][3] = it.speed_s_imag;
					lane_mem[points_held][4] = it.density_in;
					points_held++;
				end
				next_point = 0;
				walk_seg = 0;
				return 0;
			end
			plr_pkg::MODE_CLEAR: begin
				points_held = 0;
				profile_overflow = 1'b0;
				next_point = 0;
				walk_seg = 0;
				mesh_step = 0;
				return 0;
			end
			plr_pkg::MODE_NONE: return 0;
			default: ;
		endcase
		ms = (mesh_count == 0) ? 1 : mesh_count;
		if (profile_overflow) begin
			o = status_only(plr_pkg::STAT_OVERFLOW);
			return 1;
		end
		if (points_held < 2) begin
			o = status_only(plr_pkg::STAT_FEW);
			return 1;
		end
		if (next_point > ms) begin
			o = status_only(plr_pkg::STAT_FINISHED);
			return 1;
		end
		top = depth_mem[0];
		bot = depth_mem[points_held - 1];
		if (next_point == 0) mesh_step = sat_value((bot - top) / longint'(ms));
		z = (next_point == ms) ? bot : sat_value(top + longint'(next_point) * mesh_step);
		// Walk forward only, never past the last segment
		seg = walk_seg;
		if (seg > points_held - 2) seg = points_held - 2;
		while (seg < points_held - 2 && z > depth_mem[seg + 1]) seg++;
		walk_seg = seg;
		r = depth_fraction(z - depth_mem[seg], depth_mem[seg + 1] - depth_mem[seg]);
		for (int k = 0; k < plr_pkg::LANES; k++)
			v[k] = blend_lane(lane_mem[seg][k], lane_mem[seg + 1][k], r);
		o.mesh_index = next_point[plr_pkg::MESH_W-1:0];
		o.mesh_depth = z[31:0];
		o.out_p_real = v[0][31:0];
		o.out_p_imag = v[1][31:0];
		o.out_s_real = v[2][31:0];
		o.out_s_imag = v[3][31:0];
		o.out_density = v[4][31:0];
		o.final_point = (next_point == ms);
		o.status = plr_pkg::STAT_OK;
		next_point++;
		return 1;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check each mesh point against the oldest prediction
	always @(posedge clk) begin
		if (result_valid) begin
			points_seen++;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				plr_pkg::out_item_t e;
				e = expected_points.pop_front();
				if (result.mesh_index !== e.mesh_index || result.mesh_depth !== e.mesh_depth ||
					result.out_p_real !== e.out_p_real || result.out_p_imag !== e.out_p_imag ||
					result.out_s_real !== e.out_s_real || result.out_s_imag !== e.out_s_imag ||
					result.out_density !== e.out_density ||
					result.final_point !== e.final_point || result.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", e, result);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction and no result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Hold one transaction until taken, then predict it
	task automatic send_item(plr_pkg::in_item_t it, bit fixed = 0,
		plr_pkg::status_t st = plr_pkg::STAT_OK);
		plr_pkg::out_item_t o;
		request <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		if (predict_mesh_point(it, o)) expected_points.push_back(fixed ? status_only(st) : o);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every prediction has arrived
	task automatic drain_block();
		start <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_segments(int value);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= value[plr_pkg::MESH_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		mesh_count = value & 16'hFFFF;
		@(posedge clk);
	endtask

	function automatic plr_pkg::in_item_t make_item(plr_pkg::mode_t m, logic [31:0] z,
		logic [31:0] val);
		plr_pkg::in_item_t it;
		it.mode = m;
		it.point_depth = z;
		it.speed_p_real = val;
		it.speed_p_imag = ~val;
		it.speed_s_real = val ^ 32'h5A5A_A5A5;
		it.speed_s_imag = val + 32'd12345;
		it.density_in = val >>> 1;
		return it;
	endfunction

	function automatic plr_pkg::in_item_t random_item(plr_pkg::mode_t m, logic [31:0] z);
		plr_pkg::in_item_t it;
		it = make_item(m, z, $urandom);
		it.speed_p_imag = $urandom;
		it.speed_s_real = $urandom;
		it.speed_s_imag = $urandom;
		it.density_in = $urandom;
		return it;
	endfunction

	function automatic void add_row(plr_pkg::mode_t m, logic [31:0] z, logic [31:0] val,
		bit fixed = 0, plr_pkg::status_t st = plr_pkg::STAT_OK);
		stim_row_t row;
		row.it = make_item(m, z, val);
		row.fixed = fixed;
		row.st = st;
		stim_rows.push_back(row);
	endfunction

	// One random run: an overflow case, noise, or a load-then-emit run with random content
	task automatic mesh_run();
		int kind;
		int n;
		int ms;
		int span;
		int depths[$];
		kind = $urandom_range(0, 99);
		ms = (mesh_count == 0) ? 1 : mesh_count;
		if (kind < 6) begin
			// Overfill the profile, then emit into the overflow
			send_item(make_item(plr_pkg::MODE_CLEAR, 0, 0));
			n = plr_pkg::MAX_POINTS_DEF + $urandom_range(1, 2);
			for (int k = 0; k < n; k++) send_item(random_item(plr_pkg::MODE_APPEND, k * 65536));
			repeat (2) send_item(random_item(plr_pkg::MODE_EMIT, $urandom));
			send_item(make_item(plr_pkg::MODE_CLEAR, 0, 0));
		end else if (kind < 14) begin
			// Noise: any mode, any content
			repeat ($urandom_range(1, 4))
				send_item(random_item(plr_pkg::mode_t'($urandom_range(0, 3)), $urandom));
		end else begin
			if (kind < 90) send_item(random_item(plr_pkg::MODE_CLEAR, $urandom));
			n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 8);
			if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 63);
			span = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) begin
				case (span)
					0: depths.push_back($urandom);
					1: depths.push_back($urandom_range(0, 32'h0100_0000));
					default: depths.push_back(int'($urandom_range(0, 400)) << 16);
				endcase
				if (k > 0 && $urandom_range(0, 7) == 0) depths[k] = depths[k - 1];
			end
			if ($urandom_range(0, 9) == 0) depths.rsort();
			else if ($urandom_range(0, 19) != 0) depths.sort();
			foreach (depths[k]) send_item(random_item(plr_pkg::MODE_APPEND, depths[k]));
			n = (ms > 12) ? $urandom_range(1, 12) : ms + 1 + $urandom_range(0, 2);
			repeat (n) send_item(random_item(plr_pkg::MODE_EMIT, $urandom));
		end
	endtask

	initial begin
		int phase_cfg[4];
		int phase_gap[4];
		int phase_end;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		items_sent = 0;
		points_seen = 0;
		idle_cycles = 0;
		gap_pct = 0;
		points_held = 0;
		next_point = 0;
		walk_seg = 0;
		mesh_step = 0;
		profile_overflow = 1'b0;
		mesh_count = plr_pkg::MESH_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: status codes typed in, mesh points predicted
		add_row(plr_pkg::MODE_EMIT, 0, 0, 1, plr_pkg::STAT_FEW);
		add_row(plr_pkg::MODE_APPEND, 32'h8000_0000, 32'h8000_0000);
		add_row(plr_pkg::MODE_EMIT, 0, 0, 1, plr_pkg::STAT_FEW);
		add_row(plr_pkg::MODE_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0, 1, plr_pkg::STAT_FINISHED);
		add_row(plr_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_row(plr_pkg::MODE_APPEND, 32'h7FFF_FFFF, 32'h0001_0000);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_CLEAR, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0, 1, plr_pkg::STAT_FEW);
		add_row(plr_pkg::MODE_APPEND, 32'h0005_0000, 32'h0000_0000);
		add_row(plr_pkg::MODE_APPEND, 32'h0005_0000, 32'hFFFF_FFFF);
		add_row(plr_pkg::MODE_APPEND, 32'h0001_0000, 32'h0100_0000);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_EMIT, 0, 0);
		add_row(plr_pkg::MODE_CLEAR, 0, 0);
		write_segments(2);
		foreach (stim_rows[k]) send_item(stim_rows[k].it, stim_rows[k].fixed, stim_rows[k].st);

		// Random phases, each with its own mesh size and sender gaps
		phase_cfg = '{1, 65535, 0, 0};
		phase_gap = '{0, 53, 12, 0};
		phase_cfg[3] = $urandom_range(2, 9);
		for (int ph = 0; ph < 4; ph++) begin
			write_segments(phase_cfg[ph]);
			gap_pct = phase_gap[ph];
			phase_end = items_sent + 125;
			while (items_sent < phase_end) mesh_run();
		end

		// Drain and look for leftovers
		start <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_points.size() != 0) mismatches++;
		$display("Sent %0d transactions and checked %0d mesh points over four mesh sizes,",
			items_sent, points_seen);
		$display("including overflow, short-profile and finished-run cases; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/plr_pkg.sv
hw/rtl/profile_linear_resampler.sv
tb/tb_top.sv
